/* sv/mavg_pkg.sv */
// ----------------------------------------------------------------------------
// mavg_pkg
// shared constants, stream layout and the controller/datapath interface types
// ----------------------------------------------------------------------------
package mavg_pkg;

    localparam int DEF_WINDOW_LEN   = 10;
    localparam int DEF_NUM_CHANNELS = 2;
    localparam int DEF_SAMPLE_BITS  = 10;

    // fixed field widths of the stream payload
    localparam int SAMPLE_IN_W = 10;
    localparam int AVG_W       = 10;
    localparam int COUNT_OUT_W = 4;
    localparam int TDATA_W     = 16;
    localparam int S_TUSER_W   = 2;
    localparam int M_PAD_W     = TDATA_W - AVG_W - COUNT_OUT_W;

    // request kinds
    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic accept;
        logic store;
        logic load;
        logic sum;
        logic div_init;
        logic div_step;
        logic out_load;
    } mavg_cmd_t;

    typedef struct packed {
        logic sum_done;
        logic div_last;
        logic out_free;
    } mavg_status_t;

endpackage

/* sv/two_channel_moving_average_unit.sv */
// ----------------------------------------------------------------------------
// two_channel_moving_average_unit
// per-channel moving average over the last WINDOW_LEN adc samples
// ----------------------------------------------------------------------------
// A store request (tuser[0] = 0) writes its sample into the channel's ring and
// returns nothing; it passes through the store state and back to idle. A read
// request (tuser[0] = 1) returns the truncated mean of the stored samples of
// the channel, 0 with count 0 if none are stored. It walks the stored samples
// through the single ring read port, one sample summed per cycle, then runs a
// radix-4 restoring divider, and waits while the output register still holds
// an untaken result. A finished result waits in an output register, so the
// next request is taken while it is still pending.
module two_channel_moving_average_unit
    import mavg_pkg::*;
#(
    parameter int WINDOW_LEN   = DEF_WINDOW_LEN,
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // sample[9:0], zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,   // req_type[0], channel[1]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // average[9:0], stored_count[13:10], zero pad
    output logic [0:0]           m_tuser    // channel_out[0]
);

    mavg_cmd_t    cmd;
    mavg_status_t status;

    mavg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser[0]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mavg_datapath #(
        .WINDOW_LEN   (WINDOW_LEN),
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* sv/mavg_ram.sv */
// ----------------------------------------------------------------------------
// mavg_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mavg_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 20,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/mavg_ctrl.sv */
// ----------------------------------------------------------------------------
// mavg_ctrl
// sequencer for store, sum, divide and result hand-off
// ----------------------------------------------------------------------------
module mavg_ctrl
    import mavg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         req_type,
    output logic         s_tready,
    input  mavg_status_t status,
    output mavg_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_STORE = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (req_type == REQ_READ) ? ST_LOAD : ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum = 1'b1;
                if (status.sum_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/mavg_datapath.sv */
// ----------------------------------------------------------------------------
// mavg_datapath
// sample ring, per-channel position and fill, accumulator, divider, output
// ----------------------------------------------------------------------------
module mavg_datapath
    import mavg_pkg::*;
#(
    parameter int WINDOW_LEN   = DEF_WINDOW_LEN,
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mavg_cmd_t            cmd,
    output mavg_status_t         status,
    input  logic [TDATA_W-1:0]   s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,
    output logic [0:0]           m_tuser
);

    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SLOT_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W     = $clog2(WINDOW_LEN + 1);
    localparam int DEPTH     = NUM_CHANNELS * WINDOW_LEN;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W     = SAMPLE_BITS + CNT_W;
    localparam int DIV_STEPS = (SUM_W + 1) / 2;
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int REM_W     = CNT_W + 1;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // captured request
    logic                   ch_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;

    // per-channel ring state
    logic [SLOT_W-1:0] slot_reg [NUM_CHANNELS];
    logic [CNT_W-1:0]  fill_reg [NUM_CHANNELS];

    // read pipeline
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [ADDR_W-1:0] base_reg;
    logic              rdv_reg;
    logic [SUM_W-1:0]  sum_reg;

    // divider
    logic [DIV_W-1:0]  quot_reg;
    logic [DIV_W-1:0]  quot_next;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [STEP_W-1:0] step_reg;

    // result
    logic                   m_valid_reg;
    logic [AVG_W-1:0]       avg_reg;
    logic                   chan_reg;
    logic [COUNT_OUT_W-1:0] count_reg;

    logic [SAMPLE_BITS+SAMPLE_IN_W-1:0] smp_pad;
    logic [CH_W:0]                      ch_pad;
    logic [CH_W-1:0]                    ch_idx;
    logic                               ch_ok;
    logic [ADDR_W-1:0]                  base_now;
    logic [SLOT_W-1:0]                  slot_cur;
    logic [CNT_W-1:0]                   fill_cur;
    logic                               issue;
    logic                               ram_we;
    logic [ADDR_W-1:0]                  ram_waddr;
    logic [ADDR_W-1:0]                  ram_raddr;
    logic [SAMPLE_BITS-1:0]             ram_rdata;
    logic [DIV_W-1:0]                   sum_pad;
    logic [DIV_W+AVG_W-1:0]             quot_pad;
    logic [CNT_W+COUNT_OUT_W-1:0]       cnt_pad;

    assign smp_pad  = {{SAMPLE_BITS{1'b0}}, s_tdata[SAMPLE_IN_W-1:0]};
    assign ch_pad   = {{CH_W{1'b0}}, ch_reg};
    assign ch_idx   = ch_pad[CH_W-1:0];
    assign ch_ok    = (NUM_CHANNELS > 1) || (ch_reg == 1'b0);
    assign base_now = ADDR_W'(ch_idx) * ADDR_W'(WINDOW_LEN);
    assign slot_cur = slot_reg[ch_idx];
    assign fill_cur = fill_reg[ch_idx];

    assign issue     = cmd.sum && (idx_reg != cnt_reg);
    assign ram_we    = cmd.store && ch_ok;
    assign ram_waddr = base_now + ADDR_W'(slot_cur);
    assign ram_raddr = base_reg + ADDR_W'(idx_reg);

    assign sum_pad  = DIV_W'(sum_reg);
    assign quot_pad = {{AVG_W{1'b0}}, quot_reg};
    assign cnt_pad  = {{COUNT_OUT_W{1'b0}}, cnt_reg};

    assign status.sum_done = (idx_reg == cnt_reg) && !rdv_reg;
    assign status.div_last = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign status.out_free = !m_valid_reg || m_tready;

    mavg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (smp_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // two restoring steps per cycle
    always_comb
    begin
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] rs;
        logic [DIV_W-1:0] q;
        r = rem_reg;
        q = quot_reg;
        for (int k = 0; k < 2; k++)
        begin
            rs = {r[REM_W-2:0], q[DIV_W-1]};
            q  = {q[DIV_W-2:0], 1'b0};
            if (rs >= REM_W'(cnt_reg))
            begin
                r    = rs - REM_W'(cnt_reg);
                q[0] = 1'b1;
            end
            else
            begin
                r = rs;
            end
        end
        rem_next  = r;
        quot_next = q;
    end

    // request capture and payload path
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ch_reg  <= s_tuser[1];
            smp_reg <= smp_pad[SAMPLE_BITS-1:0];
        end
        if (cmd.load)
        begin
            cnt_reg  <= ch_ok ? fill_cur : '0;
            base_reg <= base_now;
            sum_reg  <= '0;
        end
        else if (cmd.sum && rdv_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(ram_rdata);
        end
        if (cmd.div_init)
        begin
            quot_reg <= sum_pad;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
        if (cmd.out_load)
        begin
            avg_reg   <= (cnt_reg == '0) ? '0 : quot_pad[AVG_W-1:0];
            chan_reg  <= ch_reg;
            count_reg <= cnt_pad[COUNT_OUT_W-1:0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                slot_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
            idx_reg     <= '0;
            rdv_reg     <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                slot_reg[ch_idx] <= (slot_cur == SLOT_W'(WINDOW_LEN - 1)) ?
                                    '0 : slot_cur + 1'b1;
                if (fill_cur != CNT_W'(WINDOW_LEN))
                begin
                    fill_reg[ch_idx] <= fill_cur + 1'b1;
                end
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
                rdv_reg <= 1'b0;
            end
            else if (cmd.sum)
            begin
                rdv_reg <= issue;
                if (issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.div_init)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, count_reg, avg_reg};
    assign m_tuser  = chan_reg;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for two_channel_moving_average_unit
// Sends store and read requests for both channels over the request stream.
// A scoreboard keeps its own sample window per channel and predicts each read
// result. Results come back on the result stream and are compared field by
// field, with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
    import mavg_pkg::*;

    localparam int WINDOW   = DEF_WINDOW_LEN;
    localparam int CHANNELS = DEF_NUM_CHANNELS;
    localparam int RANDOM_REQUESTS = 480;
    localparam int QUIET_FROM      = 430;

    typedef struct {
        logic [AVG_W-1:0]       average;
        logic                   channel;
        logic [COUNT_OUT_W-1:0] count;
    } mean_t;

    class mean_tracker;
        logic [SAMPLE_IN_W-1:0] ring [CHANNELS][WINDOW];
        int unsigned            slot [CHANNELS];
        int unsigned            fill [CHANNELS];
        mean_t                  pending_means [$];
        int                     errors;

        function new();
            for (int c = 0; c < CHANNELS; c++)
            begin
                slot[c] = 0;
                fill[c] = 0;
                for (int i = 0; i < WINDOW; i++)
                    ring[c][i] = '0;
            end
            errors = 0;
        endfunction

        function void note_request(logic req, logic ch, logic [SAMPLE_IN_W-1:0] smp);
            int unsigned total;
            mean_t       m;
            if (req == REQ_STORE)
            begin
                ring[ch][slot[ch]] = smp;
                slot[ch] = (slot[ch] + 1 == WINDOW) ? 0 : slot[ch] + 1;
                if (fill[ch] < WINDOW)
                    fill[ch]++;
            end
            else
            begin
                total = 0;
                for (int i = 0; i < fill[ch]; i++)
                    total += ring[ch][i];
                m.average = (fill[ch] == 0) ? '0 : AVG_W'(total / fill[ch]);
                m.channel = ch;
                m.count   = COUNT_OUT_W'(fill[ch]);
                pending_means.push_back(m);
            end
        endfunction

        function void check_mean(logic [AVG_W-1:0] avg, logic ch,
                                 logic [COUNT_OUT_W-1:0] cnt);
            mean_t want;
            if (pending_means.size() == 0)
            begin
                $error("unexpected result: average %0d, channel_out %0d, stored_count %0d",
                       avg, ch, cnt);
                errors++;
            end
            else
            begin
                want = pending_means.pop_front();
                if (avg !== want.average)
                begin
                    $error("average: expected %0d, got %0d", want.average, avg);
                    errors++;
                end
                if (ch !== want.channel)
                begin
                    $error("channel_out: expected %0d, got %0d", want.channel, ch);
                    errors++;
                end
                if (cnt !== want.count)
                begin
                    $error("stored_count: expected %0d, got %0d", want.count, cnt);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [0:0]           m_tuser;

    mean_tracker means = new();
    bit          quiet = 1'b0;
    int          stall_cycles = 0;

    two_channel_moving_average_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result-side back pressure
    always @(negedge clk)
    begin
        if (stall_cycles > 0)
            stall_cycles--;
        else if (!quiet && $urandom_range(0, 7) == 0)
            stall_cycles = $urandom_range(1, 7);
        m_tready <= (stall_cycles == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            means.check_mean(m_tdata[AVG_W-1:0],
                             m_tuser[0],
                             m_tdata[AVG_W+COUNT_OUT_W-1:AVG_W]);
    end

    task automatic send_request(logic req, logic ch, logic [SAMPLE_IN_W-1:0] smp);
        s_tvalid <= 1'b1;
        s_tuser  <= {ch, req};
        s_tdata  <= {{(TDATA_W-SAMPLE_IN_W){1'b0}}, smp};
        do
            @(posedge clk);
        while (!s_tready);
        means.note_request(req, ch, smp);
        @(negedge clk);
    endtask

    task automatic pause_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_for_means();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (means.pending_means.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [SAMPLE_IN_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return SAMPLE_IN_W'($urandom);
        endcase
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty channels
        send_request(REQ_READ, 1'b0, '0);
        send_request(REQ_READ, 1'b1, 10'h3ff);
        // extreme samples, read after one store and after a second store
        send_request(REQ_STORE, 1'b0, 10'h3ff);
        send_request(REQ_READ, 1'b0, '0);
        send_request(REQ_STORE, 1'b0, '0);
        send_request(REQ_READ, 1'b0, '0);
        // fill channel 1 past the window so the ring wraps
        for (int i = 0; i < WINDOW + 1; i++)
            send_request(REQ_STORE, 1'b1, 10'h3ff);
        send_request(REQ_READ, 1'b1, '0);
        send_request(REQ_STORE, 1'b0, 10'h2aa);
        send_request(REQ_STORE, 1'b0, 10'h155);
        send_request(REQ_READ, 1'b0, '0);
        send_request(REQ_READ, 1'b1, '0);
        wait_for_means();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == QUIET_FROM)
                quiet = 1'b1;
            if (n == RANDOM_REQUESTS / 2)
                wait_for_means();
            if (!quiet && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 7));
            send_request(($urandom_range(0, 9) < 6) ? REQ_STORE : REQ_READ,
                         1'($urandom_range(0, 1)), pick_sample());
        end

        wait_for_means();
        repeat (30) @(negedge clk);
        if (means.errors == 0)
            $display("two_channel_moving_average_unit: match");
        else
            $display("two_channel_moving_average_unit: mismatch");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("two_channel_moving_average_unit: mismatch");
        $finish;
    end

endmodule

/* sim.f */
sv/mavg_pkg.sv
sv/mavg_ram.sv
sv/mavg_ctrl.sv
sv/mavg_datapath.sv
sv/two_channel_moving_average_unit.sv
dv/testbench.sv
